// ===== sv/flush_when_full_page_tracker_top_defines.svh =====
// assertion helpers shared by the page tracker rtl
`ifndef FLUSH_WHEN_FULL_PAGE_TRACKER_TOP_DEFINES_SVH
`define FLUSH_WHEN_FULL_PAGE_TRACKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define FWFPT_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);
`define FWFPT_ASSERT(label, prop, msg) \
  `FWFPT_ASSERT_CLK(label, clk, rst, prop, msg)
`else
`define FWFPT_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg)
`define FWFPT_ASSERT(label, prop, msg)
`endif

`endif

// ===== sv/fwfpt_pkg.sv =====
package fwfpt_pkg;

  localparam int PAGE_W         = 20;
  localparam int LIMIT_W        = 7;
  localparam int CFG_DATA_W     = 8;
  localparam int COUNT_W        = 32;
  localparam int FRAMES_OUT_W   = 7;
  localparam int IN_DATA_W      = 24;
  localparam int IN_USER_W      = 2;
  localparam int OUT_FIELDS_W   = 2 + FRAMES_OUT_W + 4 * COUNT_W;
  localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int DEF_MAX_FRAMES = 64;
  localparam int DEF_PAGE_BITS  = 20;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== sv/fwfpt_ctrl.sv =====
module fwfpt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fwfpt_pkg::status_t st,
  output fwfpt_pkg::cmd_t    cmd
);
  import fwfpt_pkg::*;

  typedef enum logic {
    IDLE,
    SCAN
  } state_t;

  state_t state;

  always_comb begin
    cmd.load   = in_valid && in_ready;
    cmd.scan   = (state == SCAN);
    cmd.commit = (state == SCAN) && st.scan_done && st.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.load) begin
            state    <= SCAN;
            in_ready <= 1'b0;
          end
        end
        SCAN: begin
          if (cmd.commit) begin
            state    <= IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== sv/fwfpt_datapath.sv =====
`include "flush_when_full_page_tracker_top_defines.svh"

module fwfpt_datapath #(
  parameter int MAX_FRAMES = fwfpt_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = fwfpt_pkg::DEF_PAGE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [fwfpt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [fwfpt_pkg::PAGE_W-1:0]      in_page,
  input  logic                              in_is_write,
  input  logic                              in_proc,
  input  fwfpt_pkg::cmd_t                   cmd,
  output fwfpt_pkg::status_t                st,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [fwfpt_pkg::OUT_DATA_W-1:0]  out_data
);
  import fwfpt_pkg::*;

  localparam int KEY_W  = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int DEPTH  = 2 << SLOT_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAMES);

  logic [LIMIT_W-1:0] frame_limit;
  logic [KEY_W-1:0]   key_q;
  logic               wr_q;
  logic               proc_q;
  logic [CNT_W-1:0]   scan_idx;
  logic               cmp_valid;
  logic               hit_flag;
  logic [KEY_W-1:0]   rdata;
  logic [KEY_W-1:0]   mem [DEPTH];
  logic [CNT_W-1:0]   frames_used [2];
  logic [COUNT_W-1:0] read_total;
  logic [COUNT_W-1:0] write_total;
  logic [COUNT_W-1:0] fault_totals [2];

  logic [CNT_W-1:0]   used_sel;
  logic               issue_done;
  logic               issue;
  logic [SLOT_W:0]    raddr;
  logic [SLOT_W:0]    waddr;
  logic [CMP_W-1:0]   limit_ext;
  logic [CMP_W-1:0]   limit_sat;
  logic               full;
  logic [CNT_W-1:0]   base_used;
  logic [CNT_W-1:0]   used_new;
  logic [CNT_W-1:0]   used_out;
  logic               miss_commit;
  logic [COUNT_W-1:0] read_total_next;
  logic [COUNT_W-1:0] write_total_next;
  logic [COUNT_W-1:0] fault0_next;
  logic [COUNT_W-1:0] fault1_next;

  // slots of a process fill from the bottom, so the fill count marks the valid ones
  assign used_sel   = frames_used[proc_q];
  assign issue_done = (scan_idx == used_sel);
  assign issue      = cmd.scan && !issue_done;
  assign raddr      = {proc_q, scan_idx[SLOT_W-1:0]};

  assign limit_ext = CMP_W'(frame_limit);
  assign limit_sat = (limit_ext > MAX_CMP) ? MAX_CMP : limit_ext;
  assign full      = (CMP_W'(used_sel) >= limit_sat);
  assign base_used = full ? '0 : used_sel;
  assign used_new  = base_used + 1'b1;
  assign used_out  = hit_flag ? used_sel : used_new;
  assign waddr     = {proc_q, base_used[SLOT_W-1:0]};

  assign miss_commit = cmd.commit && !hit_flag;

  assign read_total_next  = wr_q ? read_total : sat_inc(read_total);
  assign write_total_next = wr_q ? sat_inc(write_total) : write_total;
  assign fault0_next = (miss_commit && !proc_q) ? sat_inc(fault_totals[0]) : fault_totals[0];
  assign fault1_next = (miss_commit && proc_q) ? sat_inc(fault_totals[1]) : fault_totals[1];

  assign st.scan_done = hit_flag || (issue_done && !cmp_valid);
  assign st.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (miss_commit) begin
      mem[waddr] <= key_q;
    end
    if (issue) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q  <= in_page[KEY_W-1:0];
      wr_q   <= in_is_write;
      proc_q <= in_proc;
    end
    if (cmd.commit) begin
      out_data <= OUT_DATA_W'({fault1_next, fault0_next, write_total_next,
                               read_total_next, FRAMES_OUT_W'(used_out),
                               !hit_flag && full, hit_flag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit     <= LIMIT_RESET;
      scan_idx        <= '0;
      cmp_valid       <= 1'b0;
      hit_flag        <= 1'b0;
      frames_used[0]  <= '0;
      frames_used[1]  <= '0;
      read_total      <= '0;
      write_total     <= '0;
      fault_totals[0] <= '0;
      fault_totals[1] <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frame_limit <= cfg_data[LIMIT_W-1:0];
      end
      if (cmd.load) begin
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
        hit_flag  <= 1'b0;
      end else begin
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
        cmp_valid <= issue;
        if (cmp_valid && (rdata == key_q)) begin
          hit_flag <= 1'b1;
        end
      end
      if (cmd.commit) begin
        read_total      <= read_total_next;
        write_total     <= write_total_next;
        fault_totals[0] <= fault0_next;
        fault_totals[1] <= fault1_next;
        if (!hit_flag) begin
          frames_used[proc_q] <= used_new;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `FWFPT_ASSERT(a_used_bounded, (CMP_W'(frames_used[0]) <= MAX_CMP) && (CMP_W'(frames_used[1]) <= MAX_CMP), "frame count above limit")
  `FWFPT_ASSERT(a_no_overwrite, cmd.commit |-> (!out_valid || out_ready), "result overwritten before taken")
  `FWFPT_ASSERT(a_miss_holds_page, miss_commit |=> (used_sel != '0), "miss left process empty")
  `FWFPT_ASSERT(a_scan_in_range, cmd.scan |-> (scan_idx <= used_sel), "scan ran past filled slots")

endmodule

// ===== sv/flush_when_full_page_tracker_top.sv =====
// flush-when-full page tracker for two processes. each input item is one memory
// reference; exactly one result item comes back for it, in order. a hit leaves the
// resident set alone; a miss counts a fault and, if the process already holds
// frame_limit pages (saturated at MAX_FRAMES, zero acting as one), drops all of its
// pages before the new page goes in. the resident pages of the process sit in a
// single-port memory that is scanned one slot per cycle with a registered read, and a
// hit ends the scan early. a previous result still waiting for m_axis_tready holds
// up the result of the current item, and with it the next acceptance. a finished
// result waits in an output register, so the next item is accepted while it is held.
// the user must write frame_limit through the cfg channel only while no item is in
// flight; the block itself does not enforce it.
module flush_when_full_page_tracker_top #(
  parameter int MAX_FRAMES = fwfpt_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = fwfpt_pkg::DEF_PAGE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration: frame_limit in bits 6:0
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fwfpt_pkg::CFG_DATA_W-1:0] cfg_data,
  // reference items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [fwfpt_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // page[19:0], zero pad
  input  logic [fwfpt_pkg::IN_USER_W-1:0]  s_axis_tuser,  // is_write[0], process[1]
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // hit[0], flushed[1], frames_in_use[8:2], reads_seen[40:9], writes_seen[72:41],
  // faults_first[104:73], faults_second[136:105], zero pad
  output logic [fwfpt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import fwfpt_pkg::*;

  cmd_t    cmd;
  status_t st;

  // the limit register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencing: idle, then scan until a match or the end of the filled slots and a free result register
  fwfpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // page memory, fill counts, counters and the result register
  fwfpt_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .in_page     (s_axis_tdata[PAGE_W-1:0]),
    .in_is_write (s_axis_tuser[0]),
    .in_proc     (s_axis_tuser[1]),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_data    (m_axis_tdata)
  );

endmodule
